### rtl/dsat_pkg.sv
// ---------------------------------------------------------------------------
// dsat_pkg
// shared widths, types and constants of the dsatur coloring unit
// ---------------------------------------------------------------------------
package dsat_pkg;

  localparam int MaxVertices = 64;
  localparam int VtxW        = 6;
  localparam int CntW        = 7;
  localparam int ColW        = 6;
  localparam int QueueDepth  = 2;

  typedef logic [VtxW-1:0]        vtx_t;
  typedef logic [CntW-1:0]        cnt_t;
  typedef logic [ColW-1:0]        col_t;
  typedef logic [MaxVertices-1:0] row_t;

  // classified item passed from the front part to the back part
  typedef struct packed {
    logic store;
    vtx_t a;
    vtx_t b;
    logic last;
  } cmd_t;

endpackage

### rtl/dsat_front.sv
// ---------------------------------------------------------------------------
// dsat_front
// accepts edge items, drops self-loops and bare items unless they end the graph, queues commands
// ---------------------------------------------------------------------------
module dsat_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dsat_pkg::vtx_t     vertex_a,
  input  dsat_pkg::vtx_t     vertex_b,
  input  logic               edge_valid,
  input  logic               last_edge,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output dsat_pkg::cmd_t     cmd
);
  import dsat_pkg::*;

  cmd_t q [QueueDepth];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;
  logic push;
  logic pop;
  cmd_t cmd_in;

  assign in_ready  = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_ptr];
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    cmd_in.store = edge_valid && (vertex_a != vertex_b);
    cmd_in.a     = vertex_a;
    cmd_in.b     = vertex_b;
    cmd_in.last  = last_edge;
    push = in_valid && in_ready && (cmd_in.store || last_edge);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/dsat_back.sv
// ---------------------------------------------------------------------------
// dsat_back
// adjacency store and dsatur sequencer, one vertex scanned per cycle
// ---------------------------------------------------------------------------
module dsat_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  dsat_pkg::cmd_t     cmd,
  input  dsat_pkg::cnt_t     vertex_count,
  output logic               out_valid,
  input  logic               out_ready,
  output dsat_pkg::vtx_t     vertex_index,
  output dsat_pkg::col_t     vertex_color,
  output dsat_pkg::col_t     peak_color,
  output logic               last_result
);
  import dsat_pkg::*;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_DEG   = 4'd1;
  localparam logic [3:0] S_PICK  = 4'd2;
  localparam logic [3:0] S_FETCH = 4'd3;
  localparam logic [3:0] S_COLOR = 4'd4;
  localparam logic [3:0] S_UPD   = 4'd5;
  localparam logic [3:0] S_ORD   = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;
  localparam logic [3:0] S_CLR   = 4'd9;

  logic [3:0] state;
  row_t adj [MaxVertices];
  row_t used [MaxVertices];
  cnt_t sat [MaxVertices];
  cnt_t deg [MaxVertices];
  col_t color [MaxVertices];
  row_t uncol;
  vtx_t idx;
  vtx_t last_idx;
  vtx_t best;
  cnt_t best_sat;
  cnt_t best_deg;
  row_t best_row;
  logic found;
  col_t cur_col;
  col_t hi_col;
  cnt_t steps;
  row_t mask;
  logic rv_valid;

  // one shared read address, read data registered and valid in the next cycle
  vtx_t raddr;
  row_t adj_q;
  row_t used_q;
  cnt_t sat_q;
  cnt_t deg_q;
  col_t color_q;
  logic issue;
  logic tail;
  logic pv;
  vtx_t pidx;
  col_t free_col;
  logic better;

  // vertices up to last_idx, i.e. below n (vertex 0 always included)
  always_comb begin
    for (int i = 0; i < MaxVertices; i++) begin
      mask[i] = (i[VtxW:0] <= {1'b0, last_idx});
    end
  end

  assign cmd_ready = (state == S_LOAD);
  assign out_valid = rv_valid;

  // scans issue one read per cycle, then the tail flag lets the last read drain
  assign raddr = (state == S_FETCH) ? best : idx;
  assign issue = ((state == S_DEG) || (state == S_PICK) || (state == S_UPD)) && !tail;

  always_ff @(posedge clk) begin
    adj_q   <= adj[raddr];
    used_q  <= used[raddr];
    sat_q   <= sat[raddr];
    deg_q   <= deg[raddr];
    color_q <= color[raddr];
  end

  // lowest color not used by neighbors of best
  always_comb begin
    free_col = col_t'(MaxVertices - 1);
    for (int c = MaxVertices - 1; c >= 0; c--) begin
      if (!used_q[c]) free_col = col_t'(c);
    end
  end

  always_comb begin
    better = !found || (sat_q > best_sat) ||
             ((sat_q == best_sat) && (deg_q > best_deg));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      idx      <= '0;
      rv_valid <= 1'b0;
      uncol    <= '1;
      found    <= 1'b0;
      last_idx <= '0;
      steps    <= '0;
      hi_col   <= '0;
      tail     <= 1'b0;
      pv       <= 1'b0;
    end else begin
      pv   <= issue;
      pidx <= idx;
      unique case (state)
        S_LOAD: begin
          if (cmd_valid) begin
            if (cmd.store) begin
              adj[cmd.a][cmd.b] <= 1'b1;
              adj[cmd.b][cmd.a] <= 1'b1;
            end
            if (cmd.last) begin
              if (vertex_count == '0) last_idx <= '0;
              else if (vertex_count > cnt_t'(MaxVertices)) last_idx <= '1;
              else last_idx <= vtx_t'(vertex_count - 1'b1);
              idx    <= '0;
              uncol  <= '1;
              hi_col <= '0;
              steps  <= '0;
              state  <= S_DEG;
            end
          end
        end
        S_DEG: begin
          if (issue) begin
            sat[idx]  <= '0;
            used[idx] <= '0;
            if (idx == last_idx) tail <= 1'b1;
            else idx <= idx + 1'b1;
          end
          if (pv) deg[pidx] <= cnt_t'($countones(adj_q & mask));
          if (tail) begin
            tail  <= 1'b0;
            idx   <= '0;
            found <= 1'b0;
            state <= S_PICK;
          end
        end
        S_PICK: begin
          if (issue) begin
            if (idx == last_idx) tail <= 1'b1;
            else idx <= idx + 1'b1;
          end
          if (pv && uncol[pidx] && better) begin
            best     <= pidx;
            best_sat <= sat_q;
            best_deg <= deg_q;
            found    <= 1'b1;
          end
          if (tail) begin
            tail  <= 1'b0;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_COLOR;
        end
        S_COLOR: begin
          cur_col     <= free_col;
          color[best] <= free_col;
          uncol[best] <= 1'b0;
          best_row    <= adj_q;
          if (free_col > hi_col) hi_col <= free_col;
          idx   <= '0;
          state <= S_UPD;
        end
        S_UPD: begin
          if (issue) begin
            if (idx == last_idx) tail <= 1'b1;
            else idx <= idx + 1'b1;
          end
          if (pv && best_row[pidx] && uncol[pidx] && mask[pidx]) begin
            if (!used_q[cur_col]) begin
              used[pidx] <= used_q | (row_t'(1) << cur_col);
              sat[pidx]  <= sat_q + 1'b1;
            end
            if (deg_q != '0) deg[pidx] <= deg_q - 1'b1;
          end
          if (tail) begin
            tail  <= 1'b0;
            idx   <= '0;
            found <= 1'b0;
            steps <= steps + 1'b1;
            if (steps[VtxW-1:0] == last_idx) state <= S_ORD;
            else state <= S_PICK;
          end
        end
        S_ORD: begin
          // color of idx is fetched here; a waiting result may leave meanwhile
          if (out_ready) rv_valid <= 1'b0;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!rv_valid || out_ready) begin
            rv_valid     <= 1'b1;
            vertex_index <= idx;
            vertex_color <= color_q;
            peak_color   <= hi_col;
            last_result  <= (idx == last_idx);
            if (idx == last_idx) state <= S_DONE;
            else begin
              idx   <= idx + 1'b1;
              state <= S_ORD;
            end
          end
        end
        S_DONE: begin
          if (out_ready) begin
            rv_valid <= 1'b0;
            idx      <= '0;
            state    <= S_CLR;
          end
        end
        S_CLR: begin
          adj[idx] <= '0;
          if (idx == vtx_t'(MaxVertices - 1)) begin
            idx   <= '0;
            state <= S_LOAD;
          end else idx <= idx + 1'b1;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

### rtl/dsatur_graph_coloring_unit.sv
// ---------------------------------------------------------------------------
// dsatur_graph_coloring_unit
// dsatur coloring of a graph loaded edge by edge, one result per vertex
// ---------------------------------------------------------------------------
// after the last transaction leaves the command queue: a degree count over n
//   vertices, n coloring rounds of pick, fetch, color and update, then n
//   results, each through the ord and out states, then the adjacency clear
// throughput: one edge per cycle while loading and the back part takes commands,
//   set by the command queue; coloring scans one vertex per cycle
// reset: synchronous; runs the adjacency clear of all 64 rows before taking edges
module dsatur_graph_coloring_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dsat_pkg::vtx_t     vertex_a,
  input  dsat_pkg::vtx_t     vertex_b,
  input  logic               edge_valid,
  input  logic               last_edge,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  dsat_pkg::cnt_t     cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dsat_pkg::vtx_t     vertex_index,
  output dsat_pkg::col_t     vertex_color,
  output dsat_pkg::col_t     peak_color,
  output logic               last_result
);
  import dsat_pkg::*;

  // vertex count register, always writable
  cnt_t vertex_count;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= cnt_t'(MaxVertices);
    end else if (cfg_valid) begin
      vertex_count <= cfg_data;
    end
  end

  // queue between front and back
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  dsat_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .vertex_a   (vertex_a),
    .vertex_b   (vertex_b),
    .edge_valid (edge_valid),
    .last_edge  (last_edge),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  dsat_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .vertex_count (vertex_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .vertex_index (vertex_index),
    .vertex_color (vertex_color),
    .peak_color   (peak_color),
    .last_result  (last_result)
  );

endmodule
